// ----- sv/bpi_pkg.sv -----
// ----------------------------------------------------------------------------
// bpi_pkg
// Shared types and constants for the battery percent interpolator: word
// formats, opcodes, level codes, register indexes and divider handshake.
// ----------------------------------------------------------------------------
package bpi_pkg;

	localparam int TABLE_ENTRIES_DEF = 21;

	localparam int OPC_W     = 1;
	localparam int IDX_W     = 5;
	localparam int MV_W      = 16;
	localparam int PCT_W     = 7;
	localparam int LVL_W     = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 7;
	localparam int QUO_W     = 13;
	localparam int FRAC_W    = 3;

	localparam logic [QUO_W-1:0] STEP_MILLI = QUO_W'(5000);
	localparam logic [QUO_W-1:0] MILLI      = QUO_W'(1000);
	localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(100);
	localparam int               PCT_STEP   = 5;

	localparam logic [OPC_W-1:0] OP_WRITE   = 1'b0;
	localparam logic [OPC_W-1:0] OP_CONVERT = 1'b1;

	localparam logic [LVL_W-1:0] LVL_NORMAL   = 2'd0;
	localparam logic [LVL_W-1:0] LVL_LOW      = 2'd1;
	localparam logic [LVL_W-1:0] LVL_CRITICAL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW      = 1'b1;

	localparam logic [CFG_W-1:0] CRITICAL_RESET = CFG_W'(10);
	localparam logic [CFG_W-1:0] LOW_RESET      = CFG_W'(20);

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic [IDX_W-1:0] entry_index;
		logic [MV_W-1:0]  entry_millivolts;
		logic [MV_W-1:0]  battery_millivolts;
	} req_word_t;

	typedef struct packed {
		logic [PCT_W-1:0] percent;
		logic [LVL_W-1:0] battery_level;
	} rsp_word_t;

	typedef struct packed {
		logic            start;
		logic [MV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- sv/bpi_div.sv -----
// ----------------------------------------------------------------------------
// bpi_div
// Restoring divider that forms 5000 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpi_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bpi_pkg::div_req_t req,
	output bpi_pkg::div_rsp_t rsp
);
	import bpi_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MV_W-1:0]  rem_q;
	logic [MV_W-1:0]  divisor_q;
	logic [QUO_W-1:0] quo_q;
	logic [MV_W:0]    trial;
	logic             qbit;

	// The remainder always stays below the divisor, so it fits in MV_W bits.
	assign trial = {rem_q, STEP_MILLI[cnt_q]};
	assign qbit  = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			rem_q     <= '0;
			quo_q     <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? MV_W'(trial - {1'b0, divisor_q}) : MV_W'(trial);
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- sv/battery_percent_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// battery_percent_interpolator_unit
// Converts a battery voltage to a charge percentage by piecewise-linear
// interpolation in a table of ascending voltages, and classes the result.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            word
//   req       in         req_valid/req_ready  table write or convert
//   rsp       out        rsp_valid/rsp_ready  percent and level
//   cfg       in         cfg_we               critical / low threshold
//
// A table write leaves the unit idle. A conversion below the first or at or
// above the last entry ends once those entries are read; otherwise it goes
// on to find segment s by the one-entry-per-cycle table scan over the
// single read port, and then runs the divider.
// Reset clears control state, presets the thresholds; the table is undefined
// until written. A result waiting at the output does not stop the next
// word from being accepted; only the final load waits for the output slot.
// ----------------------------------------------------------------------------
module battery_percent_interpolator_unit #(
	parameter int TABLE_ENTRIES = bpi_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  bpi_pkg::req_word_t                 req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output bpi_pkg::rsp_word_t                 rsp,
	input  logic                               cfg_we,
	input  logic [bpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpi_pkg::CFG_W-1:0]          cfg_wdata
);
	import bpi_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int PW = AW + 3;
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_RD_FIRST = 8'b0000_0010,
		ST_RD_LAST  = 8'b0000_0100,
		ST_SCAN     = 8'b0000_1000,
		ST_DIV      = 8'b0001_0000,
		ST_MUL      = 8'b0010_0000,
		ST_FIN      = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	logic [MV_W-1:0]  vmem_q [TABLE_ENTRIES];
	logic [MV_W-1:0]  rdata_q;
	logic [AW-1:0]    rd_addr;
	logic             rd_en;
	logic             wr_en;

	logic [CFG_W-1:0] crit_q, low_q;
	logic [MV_W-1:0]  volt_q;
	logic [MV_W-1:0]  lo_q;
	logic [MV_W-1:0]  offset_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    seg_q;
	logic [QUO_W-1:0] quo_q;
	logic [QUO_W-1:0] prod_q;
	logic [PCT_W-1:0] pct_q;
	rsp_word_t        rsp_q;
	logic             rsp_valid_q;

	div_req_t         dreq;
	div_rsp_t         drsp;

	logic             accept;
	logic             load_out;
	logic [FRAC_W-1:0] frac;
	logic [PW-1:0]    pct_sum;
	logic [LVL_W-1:0] level;

	bpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign wr_en     = accept && (req.opcode == OP_WRITE) &&
	                   ({27'd0, req.entry_index} < 32'(TABLE_ENTRIES));
	assign load_out  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// Next state, table read address and divider start.
	always_comb begin
		state_d      = state_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		dreq.start   = 1'b0;
		dreq.divisor = rdata_q - lo_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req.opcode == OP_CONVERT) begin
					rd_en   = 1'b1;
					rd_addr = '0;
					state_d = ST_RD_FIRST;
				end
			end
			ST_RD_FIRST: begin
				if (rdata_q > volt_q) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = LAST;
					state_d = ST_RD_LAST;
				end
			end
			ST_RD_LAST: begin
				if (rdata_q <= volt_q) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(1);
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// The last entry lies above the voltage, so the scan always ends.
				if (rdata_q > volt_q) begin
					dreq.start = 1'b1;
					state_d    = ST_DIV;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (drsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_FIN;
			ST_FIN:  state_d = ST_DONE;
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// The integer part of seg*5000 / 1000 is exact; only the fraction needs
	// dividing, and the product is known to stay below 5000.
	always_comb begin
		if (prod_q >= 4 * MILLI) begin
			frac = FRAC_W'(4);
		end else if (prod_q >= 3 * MILLI) begin
			frac = FRAC_W'(3);
		end else if (prod_q >= 2 * MILLI) begin
			frac = FRAC_W'(2);
		end else if (prod_q >= MILLI) begin
			frac = FRAC_W'(1);
		end else begin
			frac = '0;
		end
		pct_sum = PW'(seg_q) * PW'(PCT_STEP) + PW'(frac);
	end

	always_comb begin
		if (pct_q < crit_q) begin
			level = LVL_CRITICAL;
		end else if (pct_q < low_q) begin
			level = LVL_LOW;
		end else begin
			level = LVL_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			crit_q      <= CRITICAL_RESET;
			low_q       <= LOW_RESET;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_CRITICAL: crit_q <= cfg_wdata;
					REG_LOW:      low_q  <= cfg_wdata;
					default:      ;
				endcase
			end
		end
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vmem_q[AW'(req.entry_index)] <= req.entry_millivolts;
		end
		if (rd_en) begin
			rdata_q <= vmem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				volt_q <= req.battery_millivolts;
				idx_q  <= AW'(1);
			end
			ST_RD_FIRST: begin
				lo_q  <= rdata_q;
				pct_q <= '0;
			end
			ST_RD_LAST: begin
				pct_q <= PCT_FULL;
			end
			ST_SCAN: begin
				if (rdata_q > volt_q) begin
					seg_q    <= idx_q - 1'b1;
					offset_q <= volt_q - lo_q;
				end else begin
					lo_q  <= rdata_q;
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_DIV: begin
				quo_q <= drsp.quotient;
			end
			ST_MUL: begin
				prod_q <= QUO_W'(quo_q * offset_q);
			end
			ST_FIN: begin
				pct_q <= (pct_sum > PW'(PCT_FULL)) ? PCT_FULL : PCT_W'(pct_sum);
			end
			default: ;
		endcase
		if (load_out) begin
			rsp_q.percent       <= pct_q;
			rsp_q.battery_level <= level;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- sv/bpi_checker.sv -----
// ----------------------------------------------------------------------------
// bpi_checker
// Port-level checks for the battery percent interpolator, bound to the top.
// ----------------------------------------------------------------------------
module bpi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input bpi_pkg::req_word_t            req,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input bpi_pkg::rsp_word_t            rsp,
	input logic                          cfg_we,
	input logic [bpi_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bpi_pkg::CFG_W-1:0]     cfg_wdata
);
	import bpi_pkg::*;

	// A result never exceeds full charge.
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.percent <= PCT_FULL)
		else $error("percent above full charge");

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// A table write never produces a result word.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.opcode == OP_WRITE && !rsp_valid |=> !rsp_valid)
		else $error("table write produced a result");

	// A conversion occupies the unit: no word is taken in the next cycle.
	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.opcode == OP_CONVERT |=> !req_ready)
		else $error("word accepted during a conversion");

endmodule

bind battery_percent_interpolator_unit bpi_checker u_bpi_checker (.*);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for battery_percent_interpolator_unit. A queue of
// table writes and conversions feeds a valid/ready driver, and an internal
// copy of the table and thresholds predicts each percent and level. A
// monitor checks every result word in order, under random stalls on both
// sides, across several threshold settings that include the extremes.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpi_pkg::*;

	localparam int N_ENTRIES    = TABLE_ENTRIES_DEF;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 100;
	localparam int DRAIN_CYCLES = 64;
	localparam int QUIET_LIMIT  = 5000;
	localparam int LONG_HOLD    = 400;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_word_t            req       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b1;
	rsp_word_t            rsp;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CRITICAL;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	req_word_t pending_words [$];
	rsp_word_t exp_readings [$];

	// Table and thresholds as seen at acceptance time, used for prediction.
	logic [MV_W-1:0]  shadow_mv [N_ENTRIES];
	logic [CFG_W-1:0] crit_pct = CRITICAL_RESET;
	logic [CFG_W-1:0] low_pct  = LOW_RESET;

	// Table as queued by the stimulus, used only to aim voltages.
	int gen_mv [N_ENTRIES];

	int          errors = 0;
	int          n_read = 0;
	int unsigned drv_gap = 0, drv_calm = 0;
	int unsigned rx_hold = 0, rx_calm = 0;
	int unsigned quiet = 0;

	battery_percent_interpolator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic logic [PCT_W-1:0] charge_pct(input logic [MV_W-1:0] v);
		int unsigned seg, lo, span, acc;
		int i;
		seg = 0;
		if (shadow_mv[0] > v) return '0;
		if (shadow_mv[N_ENTRIES-1] <= v) return PCT_FULL;
		// Scanning downward leaves seg just below the first entry above v.
		for (i = N_ENTRIES - 1; i >= 1; i--)
			if (shadow_mv[i] > v) seg = i - 1;
		lo   = shadow_mv[seg];
		span = shadow_mv[seg + 1] - lo;
		acc  = seg * STEP_MILLI + (STEP_MILLI / span) * (v - lo);
		acc  = acc / MILLI;
		return (acc > PCT_FULL) ? PCT_FULL : PCT_W'(acc);
	endfunction

	function automatic logic [LVL_W-1:0] level_for(input logic [PCT_W-1:0] p);
		if (p < crit_pct) return LVL_CRITICAL;
		if (p < low_pct) return LVL_LOW;
		return LVL_NORMAL;
	endfunction

	function automatic int unsigned draw_gap(input int unsigned calm);
		return (calm != 0) ? 0 : $urandom_range(0, 8);
	endfunction

	// Mostly aims near or at the table, sometimes anywhere in range.
	function automatic int pick_mv();
		int lo, hi, i;
		lo = 65535;
		hi = 0;
		for (i = 0; i < N_ENTRIES; i++) begin
			if (gen_mv[i] < lo) lo = gen_mv[i];
			if (gen_mv[i] > hi) hi = gen_mv[i];
		end
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 65535);
			1: return gen_mv[$urandom_range(0, N_ENTRIES - 1)];
			2: return (gen_mv[0] == 0) ? 0 : gen_mv[0] - 1;
			3: return gen_mv[N_ENTRIES-1];
			4: return (gen_mv[N_ENTRIES-1] == 0) ? 0 : gen_mv[N_ENTRIES-1] - 1;
			default: return $urandom_range((lo > 50) ? lo - 50 : 0,
				(hi < 65485) ? hi + 50 : 65535);
		endcase
	endfunction

	task automatic queue_write(input int idx, input int mv);
		req_word_t w;
		w.opcode             = OP_WRITE;
		w.entry_index        = idx[IDX_W-1:0];
		w.entry_millivolts   = mv[MV_W-1:0];
		w.battery_millivolts = MV_W'($urandom);
		pending_words.push_back(w);
		if (idx < N_ENTRIES) gen_mv[idx] = mv;
	endtask

	task automatic queue_convert(input int mv);
		req_word_t w;
		w.opcode             = OP_CONVERT;
		w.entry_index        = IDX_W'($urandom);
		w.entry_millivolts   = MV_W'($urandom);
		w.battery_millivolts = mv[MV_W-1:0];
		pending_words.push_back(w);
	endtask

	// Ascending table with random base and steps; a zero step repeats an entry.
	task automatic queue_table(input int maxstep);
		int mv, i;
		mv = $urandom_range(0, 65535 - (N_ENTRIES - 1) * maxstep);
		for (i = 0; i < N_ENTRIES; i++) begin
			queue_write(i, mv);
			mv += $urandom_range(0, maxstep);
		end
	endtask

	task automatic queue_random(input int n);
		int done_n, r;
		done_n = 0;
		while (done_n < n) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				case ($urandom_range(0, 3))
					0: queue_table(3);
					1: queue_table(60);
					2: queue_table(400);
					default: queue_table(3200);
				endcase
				done_n += N_ENTRIES;
			end else if (r < 7) begin
				queue_write($urandom_range(0, N_ENTRIES - 1), $urandom_range(0, 65535));
				done_n++;
			end else if (r < 9) begin
				// Index past the table: the block drops the word.
				queue_write($urandom_range(N_ENTRIES, 31), $urandom_range(0, 65535));
			end else begin
				queue_convert(pick_mv());
				done_n++;
			end
		end
	endtask

	// Sampled at the falling edge so that the driver's updates have settled.
	task automatic drain();
		while (pending_words.size() != 0 || req_valid || exp_readings.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_thresholds(input int crit, input int low);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CRITICAL;
		cfg_wdata <= crit[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_LOW;
		cfg_wdata <= low[CFG_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		crit_pct = crit[CFG_W-1:0];
		low_pct  = low[CFG_W-1:0];
	endtask

	// Request driver: predicts on acceptance, then offers the next word.
	always @(posedge clk) begin : drive_req
		req_word_t w;
		rsp_word_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				if (req.opcode == OP_CONVERT) begin
					want.percent       = charge_pct(req.battery_millivolts);
					want.battery_level = level_for(want.percent);
					exp_readings.push_back(want);
				end else if (req.entry_index < N_ENTRIES) begin
					shadow_mv[req.entry_index] = req.entry_millivolts;
				end
			end
			if (!req_valid || req_ready) begin
				if (drv_gap != 0) begin
					drv_gap   <= drv_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					req       <= w;
					req_valid <= 1'b1;
					drv_gap   <= draw_gap(drv_calm);
					if (drv_calm != 0) begin
						drv_calm <= drv_calm - 1;
					end else if ($urandom_range(0, 24) == 0) begin
						drv_calm <= $urandom_range(10, 40);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each word and sets the stall before the next.
	always @(posedge clk) begin : watch_rsp
		rsp_word_t want;
		int unsigned hold;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				n_read++;
				if (exp_readings.size() == 0) begin
					$error("unexpected word: percent %0d, battery_level %0d",
						rsp.percent, rsp.battery_level);
					errors++;
				end else begin
					want = exp_readings.pop_front();
					if (rsp.percent !== want.percent) begin
						$error("percent: expected %0d, actual %0d", want.percent, rsp.percent);
						errors++;
					end
					if (rsp.battery_level !== want.battery_level) begin
						$error("battery_level: expected %0d, actual %0d",
							want.battery_level, rsp.battery_level);
						errors++;
					end
				end
				hold = draw_gap(rx_calm);
				if (rx_calm != 0) begin
					rx_calm <= rx_calm - 1;
				end else if ($urandom_range(0, 24) == 0) begin
					rx_calm <= $urandom_range(10, 40);
				end
				// A long hold-off lets the block back up and stall its input.
				if (n_read % 400 == 150) hold = LONG_HOLD;
				rx_hold   <= hold;
				rsp_ready <= (hold == 0);
			end else if (rx_hold != 0) begin
				rx_hold   <= rx_hold - 1;
				rsp_ready <= (rx_hold == 1);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int crit_plan [PHASES];
		int low_plan [PHASES];
		int ph, i;
		crit_plan = '{10, 0, 127, 100, 101, 60, 5, 0};
		low_plan  = '{20, 0, 127, 100, 0, 30, 95, 0};
		crit_plan[PHASES-1] = $urandom_range(0, 127);
		low_plan[PHASES-1]  = $urandom_range(0, 127);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Full table first, so no conversion ever reads an unwritten entry.
		for (i = 0; i < N_ENTRIES; i++) queue_write(i, 3000 + 60 * i);
		queue_convert(0);
		queue_convert(2999);
		queue_convert(3000);
		queue_convert(3030);
		queue_convert(4199);
		queue_convert(4200);
		queue_write(31, 65535);
		queue_convert(65535);
		// A segment wider than the step leaves only the segment base.
		queue_write(N_ENTRIES - 1, 65535);
		queue_convert(65534);
		// A dip in the middle of the table: the search skips past it.
		queue_write(10, 0);
		queue_convert(3700);
		queue_write(0, 0);
		queue_convert(0);

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				drain();
				set_thresholds(crit_plan[ph], low_plan[ph]);
			end
			queue_random(PHASE_ITEMS);
		end
		drain();

		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
